// ===== rtl/angle_kalman_fusion_assert.svh =====
// Assertion macros for the angle fusion block.
// Used by the port-level checker; no other dependencies.
`ifndef ANGLE_KALMAN_FUSION_ASSERT_SVH
`define ANGLE_KALMAN_FUSION_ASSERT_SVH

// consequent checked in the same cycle, masked during reset
`define AKF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("akf assertion failed");

// consequent checked in the next cycle, masked during reset
`define AKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("akf assertion failed");

// next cycle, also active while reset is held
`define AKF_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("akf assertion failed");

`endif

// ===== rtl/akf_pkg.sv =====
// Shared types and constants for the angle fusion block.
// No dependencies.
package akf_pkg;

  localparam int FRAC_BITS = 28;
  localparam logic signed [63:0] ONE_Q28 = 64'sd268435456;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE    = 3'd0;
  localparam logic [2:0] CFG_ANGLE_N = 3'd1;
  localparam logic [2:0] CFG_BIAS_N  = 3'd2;
  localparam logic [2:0] CFG_MEAS_N  = 3'd3;
  localparam logic [2:0] CFG_PERIOD  = 3'd4;
  localparam logic [2:0] CFG_BLEND   = 3'd5;

  localparam logic [30:0] RST_ANGLE_N = 31'd268435;
  localparam logic [30:0] RST_BIAS_N  = 31'd805306;
  localparam logic [30:0] RST_MEAS_N  = 31'd134217728;
  localparam logic [30:0] RST_PERIOD  = 31'd1342177;
  localparam logic [28:0] RST_BLEND   = 29'd5368709;

  typedef logic [3:0] step_t;

  // Kalman steps
  localparam step_t ST_PA  = 4'd0;   // angle predict
  localparam step_t ST_P00 = 4'd1;
  localparam step_t ST_P01 = 4'd2;
  localparam step_t ST_P10 = 4'd3;
  localparam step_t ST_P11 = 4'd4;
  localparam step_t ST_K0  = 4'd5;   // gain divides
  localparam step_t ST_K1  = 4'd6;
  localparam step_t ST_C10 = 4'd7;   // covariance correct, in-place order
  localparam step_t ST_C00 = 4'd8;
  localparam step_t ST_C11 = 4'd9;
  localparam step_t ST_C01 = 4'd10;
  localparam step_t ST_CB  = 4'd11;  // bias correct, before angle
  localparam step_t ST_CA  = 4'd12;
  // complementary steps
  localparam step_t ST_MP  = 4'd13;
  localparam step_t ST_MW  = 4'd14;
  localparam step_t ST_MX  = 4'd15;

  typedef struct packed {
    logic  load;   // capture input transaction
    logic  start;  // launch arithmetic for step
    logic  wb;     // write back step result
    logic  fin;    // produce result transaction
    step_t step;
  } akf_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic out_full;
    logic mode;
  } akf_stat_t;

endpackage

// ===== rtl/akf_arith.sv =====
// Shared iterative multiply / divide unit, one bit per cycle.
// Depends on akf_pkg.
module akf_arith #(
  parameter int OW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 is_div,
  input  logic signed [OW-1:0] a,
  input  logic signed [OW-1:0] b,
  output logic                 done,
  output logic signed [63:0]   res
);
  import akf_pkg::*;

  localparam int MW = OW;
  localparam int QW = MW + FRAC_BITS;
  localparam int PW = 2 * MW;
  localparam int CW = $clog2(QW + 1);
  localparam int RW = (PW + 1 > 62) ? PW + 1 : 62;
  localparam int XW = (QW > 62) ? QW : 62;
  localparam logic [RW-1:0] LIM_R = RW'(1) << 61;
  localparam logic [XW-1:0] LIM_X = XW'(1) << 61;
  localparam logic [PW:0]   RND   = (PW + 1)'((64'd1 << FRAC_BITS) - 64'd1);

  logic          div_r, neg_r, nz_r, run_r, fin_r, done_r;
  logic [MW-1:0] mcand_r, rem_r;
  logic [PW-1:0] prod_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic signed [63:0] res_r;

  logic [MW-1:0] ua, ub;
  logic [MW:0]   sum, rem_sh;
  logic          ge;
  logic [PW:0]   pr;
  logic [RW-1:0] sh, mmag;
  logic [XW-1:0] qx, dmag;
  logic [61:0]   mag;
  logic signed [63:0] fres;
  logic [CW-1:0] last;

  assign ua = a[OW-1] ? (~$unsigned(a) + 1'b1) : $unsigned(a);
  assign ub = b[OW-1] ? (~$unsigned(b) + 1'b1) : $unsigned(b);

  assign sum    = {1'b0, prod_r[PW-1:MW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
  assign rem_sh = {rem_r, quo_r[QW-1]};
  assign ge     = rem_sh >= {1'b0, mcand_r};
  assign last   = div_r ? CW'(QW - 1) : CW'(MW - 1);

  // floor rounding for negative products, clamp to 2^61
  assign pr   = {1'b0, prod_r} + ((neg_r && nz_r) ? RND : '0);
  assign sh   = RW'(pr >> FRAC_BITS);
  assign mmag = (sh > LIM_R) ? LIM_R : sh;
  assign qx   = XW'(quo_r);
  assign dmag = (qx >= LIM_X) ? LIM_X : qx;

  always_comb begin
    mag = div_r ? dmag[61:0] : mmag[61:0];
    if (div_r && !nz_r) begin
      fres = '0;
    end else if (neg_r) begin
      fres = -$signed({2'b00, mag});
    end else begin
      fres = $signed({2'b00, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == last) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r   <= is_div;
      neg_r   <= a[OW-1] ^ b[OW-1];
      nz_r    <= is_div ? (ub != '0) : ((ua != '0) && (ub != '0));
      mcand_r <= is_div ? ub : ua;
      prod_r  <= {{MW{1'b0}}, ub};
      quo_r   <= {ua, {FRAC_BITS{1'b0}}};
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (div_r) begin
        rem_r <= ge ? MW'(rem_sh - {1'b0, mcand_r}) : rem_sh[MW-1:0];
        quo_r <= {quo_r[QW-2:0], ge};
      end else begin
        prod_r <= {sum, prod_r[MW-1:1]};
      end
    end
    if (fin_r) begin
      res_r <= fres;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// ===== rtl/akf_ctrl.sv =====
// Step sequencer for the angle fusion block.
// Depends on akf_pkg.
module akf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  akf_pkg::akf_stat_t stat,
  output akf_pkg::akf_cmd_t  cmd
);
  import akf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_r, state_nxt;
  step_t      step_r, step_nxt, step_next;
  logic       step_last;

  always_comb begin
    step_last = 1'b0;
    step_next = step_r + 1'b1;
    unique case (step_r)
      ST_CA, ST_MX: step_last = 1'b1;
      default:      step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = stat.mode ? ST_MP : ST_PA;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (stat.arith_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (step_last) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt  = step_next;
          state_nxt = S_ISSUE;
        end
      end
      S_FIN: begin
        if (!stat.out_full) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_PA;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== rtl/akf_datapath.sv =====
// Filter state, configuration registers, operand select and output register.
// Depends on akf_pkg and akf_arith.
module akf_datapath #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  akf_pkg::akf_cmd_t  cmd,
  output akf_pkg::akf_stat_t stat,
  input  logic [63:0]        in_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [30:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_data
);
  import akf_pkg::*;

  localparam int OW = ((W > 31) ? W : 31) + 1;

  function automatic logic signed [W-1:0] satw(input logic signed [63:0] x);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) return W'(hi);
    if (x < lo) return W'(lo);
    return W'(x);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] sx(input logic signed [W-1:0] x);
    return 64'(x);
  endfunction

  logic          mode_r;
  logic [30:0]   an_r, bn_r, mn_r, dt_r;
  logic [28:0]   bw_r;
  logic signed [W-1:0] ang_r, bias_r, accel_r, gyro_r, k0_r, k1_r;
  logic signed [W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [63:0]  tmp_r;
  logic          out_valid_r;
  logic [31:0]   out_ang_r, out_rate_r;

  logic signed [OW-1:0] a_op, b_op;
  logic                 is_div, done;
  logic signed [63:0]   res;
  logic signed [W-1:0]  err, innov, rate_new;
  logic signed [29:0]   w_rest;

  akf_arith #(.OW(OW)) u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .is_div (is_div),
    .a      (a_op),
    .b      (b_op),
    .done   (done),
    .res    (res)
  );

  assign err      = satw(sx(accel_r) - sx(ang_r));
  assign innov    = satw(64'($signed({1'b0, mn_r})) + sx(p00_r));
  assign w_rest   = 30'(ONE_Q28) - $signed({1'b0, bw_r});
  assign rate_new = satw(sx(gyro_r) - sx(bias_r));

  always_comb begin
    is_div = 1'b0;
    a_op   = OW'(k0_r);
    b_op   = OW'($signed({1'b0, dt_r}));
    unique case (cmd.step)
      ST_PA:  a_op = OW'(satw(sx(gyro_r) - sx(bias_r)));
      ST_P00: a_op = OW'(satw(64'($signed({1'b0, an_r})) - sx(p01_r) - sx(p10_r)));
      ST_P01, ST_P10: a_op = OW'(satw(-sx(p11_r)));
      ST_P11: a_op = OW'($signed({1'b0, bn_r}));
      ST_K0: begin
        is_div = 1'b1;
        a_op   = OW'(p00_r);
        b_op   = OW'(innov);
      end
      ST_K1: begin
        is_div = 1'b1;
        a_op   = OW'(p10_r);
        b_op   = OW'(innov);
      end
      ST_C10: begin a_op = OW'(k1_r); b_op = OW'(p00_r); end
      ST_C00: begin a_op = OW'(k0_r); b_op = OW'(p00_r); end
      ST_C11: begin a_op = OW'(k1_r); b_op = OW'(p01_r); end
      ST_C01: begin a_op = OW'(k0_r); b_op = OW'(p01_r); end
      ST_CB:  begin a_op = OW'(k1_r); b_op = OW'(err); end
      ST_CA:  begin a_op = OW'(k0_r); b_op = OW'(err); end
      ST_MP:  a_op = OW'(gyro_r);
      ST_MW:  begin a_op = OW'($signed({1'b0, bw_r})); b_op = OW'(accel_r); end
      ST_MX:  begin a_op = OW'(w_rest); b_op = OW'(ang_r); end
      default: a_op = OW'(k0_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      an_r   <= RST_ANGLE_N;
      bn_r   <= RST_BIAS_N;
      mn_r   <= RST_MEAS_N;
      dt_r   <= RST_PERIOD;
      bw_r   <= RST_BLEND;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MODE:    mode_r <= cfg_wdata[0];
        CFG_ANGLE_N: an_r   <= cfg_wdata;
        CFG_BIAS_N:  bn_r   <= cfg_wdata;
        CFG_MEAS_N:  mn_r   <= cfg_wdata;
        CFG_PERIOD:  dt_r   <= cfg_wdata;
        CFG_BLEND:   bw_r   <= cfg_wdata[28:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r  <= '0;
      bias_r <= '0;
      p00_r  <= satw(ONE_Q28);
      p01_r  <= '0;
      p10_r  <= '0;
      p11_r  <= satw(ONE_Q28);
    end else if (cmd.wb) begin
      unique case (cmd.step)
        ST_PA, ST_CA, ST_MP: ang_r <= satw(sx(ang_r) + res);
        ST_P00: p00_r <= satw(sx(p00_r) + res);
        ST_P01: p01_r <= satw(sx(p01_r) + res);
        ST_P10: p10_r <= satw(sx(p10_r) + res);
        ST_P11: p11_r <= satw(sx(p11_r) + res);
        ST_C10: p10_r <= satw(sx(p10_r) - res);
        ST_C00: p00_r <= satw(sx(p00_r) - res);
        ST_C11: p11_r <= satw(sx(p11_r) - res);
        ST_C01: p01_r <= satw(sx(p01_r) - res);
        ST_CB:  bias_r <= satw(sx(bias_r) + res);
        ST_MX:  ang_r <= satw(tmp_r + res);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      accel_r <= satw(64'($signed(in_data[31:0])));
      gyro_r  <= satw(64'($signed(in_data[63:32])));
    end
    if (cmd.wb) begin
      if (cmd.step == ST_K0) k0_r <= satw(res);
      if (cmd.step == ST_K1) k1_r <= satw(res);
      if (cmd.step == ST_MW) tmp_r <= res;
    end
    if (cmd.fin) begin
      out_ang_r  <= sat32(sx(ang_r));
      out_rate_r <= sat32(sx(rate_new));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.arith_done = done;
  assign stat.out_full   = out_valid_r && !out_ready;
  assign stat.mode       = mode_r;
  assign out_valid       = out_valid_r;
  assign out_data        = {out_rate_r, out_ang_r};

endmodule

// ===== rtl/angle_kalman_fusion.sv =====
// Tilt angle fusion: two-state Kalman filter or complementary blend.
// Top level; depends on akf_pkg, akf_ctrl, akf_datapath.
//
// Input stream (in_*): one transaction carries an accelerometer angle and a
// gyro rate, both Q4.28. Output stream (out_*): one transaction per input,
// the updated angle and the bias-corrected rate, Q4.28, saturated to 32 bits.
// Configuration (cfg_*): index/data writes, always ready; write only while
// no sample is in flight.
// One sample is handled at a time. All multiplies and divides go through a
// single shift-add / restoring-divide unit, one bit per cycle, on operands of
// M = max(W,31)+1 bits. Kalman mode: 11 multiplies + 2 divides per sample;
// complementary mode: 3 multiplies per sample. A new input is taken only once
// the previous result sits in the output register, so one result may wait
// while the next sample is computed; if the receiver stalls longer the block
// holds before writing its next result.
// Synchronous reset clears angle, bias and output valid, sets the covariance
// to identity and the configuration registers to their defaults.
module angle_kalman_fusion #(
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] angle_estimate, [63:32] rate_estimate
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  import akf_pkg::*;

  akf_cmd_t  cmd;
  akf_stat_t stat;

  assign cfg_ready = 1'b1;

  akf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  akf_datapath #(.W(WORD_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== rtl/akf_checker.sv =====
// Port-level checks for the angle fusion block, bound to the top level.
// Depends on angle_kalman_fusion_assert.svh.
`include "angle_kalman_fusion_assert.svh"

module akf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        cfg_ready
);

  `AKF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AKF_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `AKF_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid)
  `AKF_ASSERT_NOW(a_cfg_open, 1'b1, cfg_ready)

endmodule

bind angle_kalman_fusion akf_checker u_akf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
